@@ design/assert_macros.svh @@
// Assertion macros shared by the compensation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// prop must hold at every clock edge outside reset
`define ESC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
// cond must never be seen outside reset
`define ESC_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("forbidden state");
`else
`define ESC_ASSERT(lbl, clk, rst, prop)
`define ESC_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ design/esc_pkg.sv @@
// Types, constants and helpers of the sensor compensation block
package esc_pkg;

  // pipeline geometry
  localparam int FE_STAGES    = 13;
  localparam int DIV_BITS     = 64;
  localparam int BK_DIV_FIRST = 7;
  localparam int BK_FIX       = BK_DIV_FIRST + DIV_BITS;
  localparam int BK_SQ        = BK_FIX + 1;
  localparam int BK_E1        = BK_FIX + 2;
  localparam int BK_SUM       = BK_FIX + 3;
  localparam int BK_STAGES    = BK_FIX + 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_CAL_P9      = 3'd3,
    REG_CAL_HUM     = 3'd4
  } cfg_reg_t;

  // compensation constants
  localparam logic [32:0] PRESS_X_OFFS   = 33'd128000;
  localparam logic [63:0] PRESS_NUM_BASE = 64'd1048576;
  localparam logic [63:0] PRESS_P1_BIAS  = 64'h0000_8000_0000_0000;
  localparam logic [11:0] PRESS_SCALE    = 12'd3125;
  localparam logic [31:0] TEMP_ROUND     = 32'd128;
  localparam logic [31:0] HUM_T_OFFS     = 32'd76800;
  localparam logic [31:0] HUM_X_ROUND    = 32'd16384;
  localparam logic [31:0] HUM_Y_BIAS     = 32'd32768;
  localparam logic [31:0] HUM_Y_OFFS     = 32'd2097152;
  localparam logic [31:0] HUM_Y_ROUND    = 32'd8192;
  localparam logic [31:0] HUM_CLAMP      = 32'd419430400;

  // decoded calibration set
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  // item passed from front to back
  typedef struct packed {
    logic [19:0] raw_p;
    logic [31:0] tfine;
    logic [31:0] temp;
    logic [16:0] hum;
  } mid_t;

  // finished result
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
  } res_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

endpackage

@@ design/esc_fifo.sv @@
// Small first-word-fall-through queue
`include "assert_macros.svh"
module esc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

  `ESC_NEVER(a_count_range, clk, rst, count > CW'(DEPTH))
  `ESC_ASSERT(a_count_up, clk, rst, (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
  `ESC_ASSERT(a_count_both, clk, rst, (do_wr && do_rd) |=> $stable(count))

endmodule

@@ design/esc_front.sv @@
// Front pipeline: takes raw sample sets, temperature and humidity
module esc_front import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cal_t        cal,
  input  logic        in_valid,
  output logic        in_full,
  input  logic [19:0] raw_t,
  input  logic [19:0] raw_p,
  input  logic [15:0] raw_h,
  output logic        out_valid,
  input  logic        out_ready,
  output mid_t        out_item
);

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    logic [15:0] raw_h;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [31:0] ma;
    logic [31:0] md;
    logic [31:0] va;
    logic [31:0] mb;
    logic [31:0] tfine;
    logic [31:0] temp;
    logic [31:0] hm1;
    logic [31:0] hm2;
    logic [31:0] hm3;
    logic [31:0] hx;
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] m4;
    logic [31:0] m5;
    logic [31:0] hy;
    logic [31:0] vv;
    logic [31:0] sq;
    logic [31:0] m6;
    logic [16:0] hum;
  } fe_stage_t;

  // work of one stage; all arithmetic wraps at 32 bits
  function automatic fe_stage_t fe_step(input int k, input fe_stage_t s, input cal_t c);
    fe_stage_t   r;
    logic [31:0] t;
    logic [31:0] v;
    r = s;
    case (k)
      0: begin
        r.d1 = (32'(s.raw_t) >> 3) - (32'(c.t1) << 1);
        r.d2 = (32'(s.raw_t) >> 4) - 32'(c.t1);
      end
      1: begin
        r.ma = s.d1 * 32'($signed(c.t2));
        r.md = s.d2 * s.d2;
      end
      2: begin
        r.va = asr32(s.ma, 11);
        r.mb = asr32(s.md, 12) * 32'($signed(c.t3));
      end
      3: begin
        t       = s.va + asr32(s.mb, 14);
        r.tfine = t;
        r.temp  = asr32((t << 2) + t + TEMP_ROUND, 8);
      end
      4: begin
        v     = s.tfine - HUM_T_OFFS;
        r.hm1 = v * 32'($signed(c.h6));
        r.hm2 = v * 32'(c.h3);
        r.hm3 = 32'($signed(c.h5)) * v;
      end
      5: begin
        r.hx = asr32((32'(s.raw_h) << 14) - (32'($signed(c.h4)) << 20) - s.hm3
                     + HUM_X_ROUND, 15);
        r.ha = asr32(s.hm1, 10);
        r.hb = asr32(s.hm2, 11) + HUM_Y_BIAS;
      end
      6: r.m4 = s.ha * s.hb;
      7: begin
        t     = asr32(s.m4, 10) + HUM_Y_OFFS;
        r.m5  = t * 32'($signed(c.h2));
      end
      8: r.hy = asr32(s.m5 + HUM_Y_ROUND, 14);
      9: r.vv = s.hx * s.hy;
      10: begin
        t    = asr32(s.vv, 15);
        r.sq = t * t;
      end
      11: r.m6 = asr32(s.sq, 7) * 32'(c.h1);
      12: begin
        v = s.vv - asr32(s.m6, 4);
        if (v[31]) begin
          v = '0;
        end else if (v > HUM_CLAMP) begin
          v = HUM_CLAMP;
        end
        r.hum = v[28:12];
      end
      default: r = s;
    endcase
    return r;
  endfunction

  logic [FE_STAGES:1] vld;
  fe_stage_t          pipe [1:FE_STAGES];
  fe_stage_t          head;
  logic               en;

  // whole pipe advances unless the last stage is blocked
  assign en      = !vld[FE_STAGES] || out_ready;
  assign in_full = !en;

  always_comb begin
    head       = '0;
    head.raw_t = raw_t;
    head.raw_p = raw_p;
    head.raw_h = raw_h;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FE_STAGES-1:1], in_valid};
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[1] <= fe_step(0, head, cal);
      for (int k = 1; k < FE_STAGES; k++) begin
        pipe[k+1] <= fe_step(k, pipe[k], cal);
      end
    end
  end

  assign out_valid      = vld[FE_STAGES];
  assign out_item.raw_p = pipe[FE_STAGES].raw_p;
  assign out_item.tfine = pipe[FE_STAGES].tfine;
  assign out_item.temp  = pipe[FE_STAGES].temp;
  assign out_item.hum   = pipe[FE_STAGES].hum;

endmodule

@@ design/esc_back.sv @@
// Back pipeline: 64-bit pressure compensation with a bit-per-stage divider
module esc_back import esc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cal_t cal,
  input  logic in_valid,
  output logic in_take,
  input  mid_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  typedef struct packed {
    logic [31:0]        temp;
    logic [16:0]        hum;
    logic [19:0]        raw_p;
    logic [31:0]        tfine;
    logic signed [32:0] x1;
    logic [63:0]        xx;
    logic [63:0]        mp5;
    logic [63:0]        mp2;
    logic [63:0]        x2a;
    logic [63:0]        x1a;
    logic [63:0]        x2;
    logic [63:0]        x1b;
    logic [63:0]        x1c;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        rem;
    logic [63:0]        quo;
    logic               neg;
    logic               zero;
    logic [63:0]        p;
    logic [63:0]        aal;
    logic [31:0]        aax;
    logic [63:0]        m8;
    logic [63:0]        e1r;
    logic [63:0]        e2;
    logic [31:0]        press;
  } bk_stage_t;

  // work of one stage; all arithmetic wraps at 64 bits
  function automatic bk_stage_t bk_step(input int k, input bk_stage_t s, input cal_t c);
    bk_stage_t          r;
    logic signed [65:0] sq66;
    logic signed [48:0] p49a;
    logic signed [48:0] p49b;
    logic signed [79:0] w80a;
    logic signed [79:0] w80b;
    logic [79:0]        u80;
    logic [75:0]        u76;
    logic [63:0]        a64;
    logic [63:0]        d64;
    logic [64:0]        r65;
    logic [64:0]        tr65;
    logic [31:0]        al;
    logic [31:0]        ah;
    r = s;
    if (k >= BK_DIV_FIRST && k < BK_FIX) begin
      // one restoring step of the unsigned quotient
      r65   = {s.rem, s.quo[63]};
      tr65  = r65 - {1'b0, s.den};
      r.rem = tr65[64] ? r65[63:0] : tr65[63:0];
      r.quo = {s.quo[62:0], !tr65[64]};
    end else begin
      case (k)
        0: r.x1 = 33'($signed(s.tfine)) - $signed(PRESS_X_OFFS);
        1: begin
          sq66  = $signed(s.x1) * $signed(s.x1);
          r.xx  = sq66[63:0];
          p49a  = $signed(s.x1) * $signed(c.p5);
          p49b  = $signed(s.x1) * $signed(c.p2);
          r.mp5 = 64'(p49a);
          r.mp2 = 64'(p49b);
        end
        2: begin
          w80a  = $signed(s.xx) * $signed(c.p6);
          w80b  = $signed(s.xx) * $signed(c.p3);
          r.x2a = w80a[63:0];
          r.x1a = w80b[63:0];
        end
        3: begin
          r.x2  = s.x2a + (s.mp5 << 17) + (64'($signed(c.p4)) << 35);
          r.x1b = asr64(s.x1a, 8) + (s.mp2 << 12);
        end
        4: begin
          d64   = PRESS_P1_BIAS + s.x1b;
          u80   = d64 * c.p1;
          r.x1c = u80[63:0];
          a64   = PRESS_NUM_BASE - 64'(s.raw_p);
          a64   = (a64 << 31) - s.x2;
          u76   = a64 * PRESS_SCALE;
          r.num = u76[63:0];
        end
        5: r.den = asr64(s.x1c, 33);
        6: begin
          // magnitudes and sign of the quotient
          r.zero = (s.den == '0);
          r.neg  = s.num[63] ^ s.den[63];
          r.quo  = s.num[63] ? 64'd0 - s.num : s.num;
          r.den  = s.den[63] ? 64'd0 - s.den : s.den;
          r.rem  = '0;
        end
        BK_FIX: r.p = s.neg ? 64'd0 - s.quo : s.quo;
        BK_SQ: begin
          // square of p>>13 from 32-bit halves, wrapping at 64 bits
          a64   = asr64(s.p, 13);
          al    = a64[31:0];
          ah    = a64[63:32];
          r.aal = {32'd0, al} * {32'd0, al};
          r.aax = al * ah;
          w80a  = $signed(s.p) * $signed(c.p8);
          r.m8  = w80a[63:0];
        end
        BK_E1: begin
          d64   = s.aal + {s.aax[30:0], 33'd0};
          w80b  = $signed(d64) * $signed(c.p9);
          r.e1r = w80b[63:0];
          r.e2  = asr64(s.m8, 19);
        end
        BK_SUM: begin
          a64     = s.p + asr64(s.e1r, 25) + s.e2;
          d64     = asr64(a64, 8) + (64'($signed(c.p7)) << 4);
          r.press = s.zero ? '0 : d64[31:0];
        end
        default: r = s;
      endcase
    end
    return r;
  endfunction

  logic [BK_STAGES:1] vld;
  bk_stage_t          pipe [1:BK_STAGES];
  bk_stage_t          head;
  logic               en;

  assign en      = !vld[BK_STAGES] || out_ready;
  assign in_take = en && in_valid;

  always_comb begin
    head       = '0;
    head.temp  = in_item.temp;
    head.hum   = in_item.hum;
    head.raw_p = in_item.raw_p;
    head.tfine = in_item.tfine;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BK_STAGES-1:1], in_valid};
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[1] <= bk_step(0, head, cal);
      for (int k = 1; k < BK_STAGES; k++) begin
        pipe[k+1] <= bk_step(k, pipe[k], cal);
      end
    end
  end

  assign out_valid     = vld[BK_STAGES];
  assign out_res.temp  = pipe[BK_STAGES].temp;
  assign out_res.press = pipe[BK_STAGES].press;
  assign out_res.hum   = pipe[BK_STAGES].hum;

endmodule

@@ design/env_sensor_compensation.sv @@
// Top level of the environmental sensor compensation block
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  samples  | push in, full out          | raw_temp, raw_press, raw_hum
//  results  | empty out, pop in          | temp_centi, press_q24_8, hum_q22_10
//  config   | cfg_valid in, cfg_ready out| cfg_index, cfg_data
//
// One item per cycle sustained while neither queue is full; the path runs through 13 front stages, the
// middle queue, 75 back stages (64 of them the one-bit-per-stage divider) and
// the output queue. Reset clears valids, queue levels and calibration words.
// A full middle queue freezes the front, and a full output queue the back, once their last stage holds an item.
// Config is taken every cycle (cfg_ready is always high).
module env_sensor_compensation import esc_pkg::*; #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [19:0]          raw_temp,
  input  logic [19:0]          raw_press,
  input  logic [15:0]          raw_hum,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   temp_centi,
  output logic [31:0]          press_q24_8,
  output logic [16:0]          hum_q22_10,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [47:0] cal_temp_words;
  logic [63:0] cal_press_words_a;
  logic [63:0] cal_press_words_b;
  logic [15:0] cal_press_p9;
  logic [63:0] cal_hum_words;
  cal_t        cal;

  assign cfg_ready = 1'b1;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp_words    <= '0;
      cal_press_words_a <= '0;
      cal_press_words_b <= '0;
      cal_press_p9      <= '0;
      cal_hum_words     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAL_TEMP:    cal_temp_words    <= cfg_data[47:0];
        REG_CAL_PRESS_A: cal_press_words_a <= cfg_data;
        REG_CAL_PRESS_B: cal_press_words_b <= cfg_data;
        REG_CAL_P9:      cal_press_p9      <= cfg_data[15:0];
        REG_CAL_HUM:     cal_hum_words     <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack calibration words
  always_comb begin
    cal.t1 = cal_temp_words[15:0];
    cal.t2 = cal_temp_words[31:16];
    cal.t3 = cal_temp_words[47:32];
    cal.p1 = cal_press_words_a[15:0];
    cal.p2 = cal_press_words_a[31:16];
    cal.p3 = cal_press_words_a[47:32];
    cal.p4 = cal_press_words_a[63:48];
    cal.p5 = cal_press_words_b[15:0];
    cal.p6 = cal_press_words_b[31:16];
    cal.p7 = cal_press_words_b[47:32];
    cal.p8 = cal_press_words_b[63:48];
    cal.p9 = cal_press_p9;
    cal.h1 = cal_hum_words[7:0];
    cal.h2 = cal_hum_words[23:8];
    cal.h3 = cal_hum_words[31:24];
    cal.h4 = cal_hum_words[43:32];
    cal.h5 = cal_hum_words[55:44];
    cal.h6 = cal_hum_words[63:56];
  end

  logic                     fe_valid;
  logic                     mid_full;
  mid_t                     fe_item;
  logic [$bits(mid_t)-1:0]  mid_rdata;
  mid_t                     mid_item;
  logic                     mid_empty;
  logic                     bk_take;
  logic                     bk_valid;
  logic                     out_full;
  res_t                     bk_res;
  logic [$bits(res_t)-1:0]  out_rdata;
  res_t                     out_res;

  esc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (push),
    .in_full   (full),
    .raw_t     (raw_temp),
    .raw_p     (raw_press),
    .raw_h     (raw_hum),
    .out_valid (fe_valid),
    .out_ready (!mid_full),
    .out_item  (fe_item)
  );

  esc_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (fe_valid),
    .wdata (fe_item),
    .full  (mid_full),
    .rd    (bk_take),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_item = mid_t'(mid_rdata);

  esc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (!mid_empty),
    .in_take   (bk_take),
    .in_item   (mid_item),
    .out_valid (bk_valid),
    .out_ready (!out_full),
    .out_res   (bk_res)
  );

  esc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (bk_valid),
    .wdata (bk_res),
    .full  (out_full),
    .rd    (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_res     = res_t'(out_rdata);
  assign temp_centi  = $signed(out_res.temp);
  assign press_q24_8 = out_res.press;
  assign hum_q22_10  = out_res.hum;

endmodule
